FILE: design/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII block.
// Used by sitda_ctrl, sitda_dp and signed_int_to_decimal_ascii_top.
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    localparam int DATA_W     = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(DATA_W);
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

    localparam logic [7:0]        ASCII_ZERO  = 8'd48;
    localparam logic [7:0]        ASCII_MINUS = 8'd45;
    localparam logic [DATA_W-1:0] COUNT_MAX   = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic find;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic negative;
        logic out_free;
        logic digit_last;
    } status_t;

endpackage

`default_nettype wire

FILE: design/sitda_ctrl.sv
// Controller state machine: load, binary to BCD conversion, character emission.
// Depends on sitda_pkg; drives sitda_dp through cmd_t and reads status_t.
`timescale 1ns / 1ps
`default_nettype none

module sitda_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire sitda_pkg::status_t status,
    output sitda_pkg::cmd_t       cmd
);

    sitda_pkg::state_t state_reg;
    sitda_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV:
            begin
                cmd.step = 1'b1;
                if (status.conv_last)
                begin
                    state_next = sitda_pkg::ST_FIND;
                end
            end
            sitda_pkg::ST_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = status.negative ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGIT;
            end
            sitda_pkg::ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = sitda_pkg::ST_DIGIT;
                end
            end
            sitda_pkg::ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.digit_last)
                    begin
                        state_next = sitda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sitda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/sitda_dp.sv
// Datapath: magnitude and shift-add-3 BCD registers, digit pointer,
// output register and saturating character count. Depends on sitda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitda_dp
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic signed [sitda_pkg::DATA_W-1:0] value,
    input  wire sitda_pkg::cmd_t                  cmd,
    output sitda_pkg::status_t                    status,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [7:0]                            ascii_char,
    output logic                                  last_char,
    output logic [sitda_pkg::DATA_W-1:0]          chars_total
);

    localparam int DW = sitda_pkg::DATA_W;
    localparam int BW = sitda_pkg::BCD_W;
    localparam int ND = sitda_pkg::NUM_DIGITS;
    localparam int CW = sitda_pkg::BIT_CNT_W;
    localparam int IW = sitda_pkg::DIG_IDX_W;

    logic [DW-1:0] mag_reg;
    logic [BW-1:0] bcd_reg;
    logic [CW-1:0] bit_cnt_reg;
    logic [IW-1:0] idx_reg;
    logic          neg_reg;
    logic [7:0]    char_reg;
    logic          last_reg;
    logic          out_valid_reg;
    logic [DW-1:0] count_reg;

    logic [BW-1:0] bcd_adj;
    logic [IW-1:0] top_idx;
    logic [3:0]    cur_digit;
    logic          emit;
    logic [DW-1:0] count_next;

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < ND; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                top_idx = IW'(i);
            end
        end
    end

    assign cur_digit  = bcd_reg[idx_reg*4 +: 4];
    assign emit       = cmd.emit_sign | cmd.emit_digit;
    assign count_next = (count_reg == sitda_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg     <= value[DW-1];
            mag_reg     <= value[DW-1] ? (~value + 1'b1) : value;
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            bcd_reg     <= {bcd_adj[BW-2:0], mag_reg[DW-1]};
            mag_reg     <= {mag_reg[DW-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
        if (cmd.find)
        begin
            idx_reg <= top_idx;
        end
        else if (cmd.emit_digit)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.emit_sign)
        begin
            char_reg <= sitda_pkg::ASCII_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= sitda_pkg::ASCII_ZERO + {4'd0, cur_digit};
            last_reg <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.conv_last  = (bit_cnt_reg == CW'(DW - 1));
    assign status.negative   = neg_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.digit_last = (idx_reg == '0);

    assign out_valid   = out_valid_reg;
    assign ascii_char  = char_reg;
    assign last_char   = last_reg;
    assign chars_total = count_reg;

endmodule

`default_nettype wire

FILE: design/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_ctrl and sitda_dp.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_stall  value[31:0] signed
//   output   out_valid/ out_stall ascii_char[7:0], last_char, chars_total[31:0]
//
// The controller loads a number, runs the shift-add-3 BCD conversion
// (one magnitude bit per cycle), finds the leading digit, then one
// character leaves per cycle when unstalled: 1..11 characters per number.
// Reset clears the controller and the character count.
// A stall on the output holds the emission; a new number is taken only when idle.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [sitda_pkg::DATA_W-1:0] value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [7:0]                               ascii_char,
    output logic                                     last_char,
    output logic [sitda_pkg::DATA_W-1:0]             chars_total
);

    sitda_pkg::cmd_t    cmd;
    sitda_pkg::status_t status;

    sitda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sitda_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ascii_char  (ascii_char),
        .last_char   (last_char),
        .chars_total (chars_total)
    );

endmodule

`default_nettype wire
